/* src/assert_macros.svh */
// Assertion macros used by the top RTL file of the point rotation block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// The consequent holds a fixed number of cycles after the antecedent.
`define ASSERT_AFTER(label, clk_s, rst_s, ante, n, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> ##(n) (cons)) \
    else $error("assertion failed: delayed consequent missing");

// When the consequent holds, the antecedent held a fixed number of cycles earlier.
`define ASSERT_PAST(label, clk_s, rst_s, cons, ante, n) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (cons) |-> $past(ante, n)) \
    else $error("assertion failed: no matching earlier event");

`else

`define ASSERT_AFTER(label, clk_s, rst_s, ante, n, cons)
`define ASSERT_PAST(label, clk_s, rst_s, cons, ante, n)

`endif

`endif

/* src/qpr_pkg.sv */
// Shared widths, types and register indexes of the point rotation block.
`timescale 1ns / 1ps

package qpr_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int QUAT_W      = 32;
  localparam int QUAT_FRAC   = 30;

  // Rotation matrix entries in signed Q.30.
  localparam int ENTRY_W = 37;
  localparam int DIFF_W  = COORD_WIDTH + 1;
  localparam int LO_W    = 18;
  localparam int HI_W    = ENTRY_W - LO_W;
  localparam int PL_W    = LO_W + 1 + DIFF_W;
  localparam int PH_W    = HI_W + DIFF_W;
  localparam int PROD_W  = ENTRY_W + DIFF_W;
  localparam int ACC_W   = PROD_W + 2;
  localparam int ROW_W   = ACC_W - QUAT_FRAC;
  localparam int OSUM_W  = ROW_W + 1;

  localparam logic [ACC_W-1:0] ROUND_ACC = ACC_W'(1) << (QUAT_FRAC - 1);

  localparam int PIPE_LAT = 6;

  localparam logic [2:0] REG_QUAT_W   = 3'd0;
  localparam logic [2:0] REG_QUAT_X   = 3'd1;
  localparam logic [2:0] REG_QUAT_Y   = 3'd2;
  localparam logic [2:0] REG_QUAT_Z   = 3'd3;
  localparam logic [2:0] REG_CENTRE_X = 3'd4;
  localparam logic [2:0] REG_CENTRE_Y = 3'd5;
  localparam logic [2:0] REG_CENTRE_Z = 3'd6;

  localparam logic [QUAT_W-1:0] QUAT_ONE = QUAT_W'(1) << QUAT_FRAC;

  typedef logic [3:0][QUAT_W-1:0] quat_t;
  typedef logic [2:0][2:0][ENTRY_W-1:0] mat_t;

endpackage

/* src/qpr_matrix.sv */
// Two-stage pipeline that turns the quaternion registers into the rotation matrix.
`timescale 1ns / 1ps

module qpr_matrix (
  input  logic          clk,
  input  qpr_pkg::quat_t quat,
  output qpr_pkg::mat_t  mat
);

  localparam int QP_W  = 2 * qpr_pkg::QUAT_W;
  localparam int SUM_W = qpr_pkg::ENTRY_W + qpr_pkg::QUAT_FRAC;
  localparam logic signed [SUM_W-1:0] RND = SUM_W'(1) << (qpr_pkg::QUAT_FRAC - 1);

  logic signed [qpr_pkg::QUAT_W-1:0] qw, qx, qy, qz;
  logic signed [QP_W-1:0] p_ww, p_xx, p_yy, p_zz, p_xy, p_wz, p_wy, p_xz, p_yz, p_wx;

  function automatic logic signed [SUM_W-1:0] sx(input logic signed [QP_W-1:0] p);
    return {{(SUM_W - QP_W){p[QP_W-1]}}, p};
  endfunction

  function automatic logic [qpr_pkg::ENTRY_W-1:0] fold(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] t;
    t = s + RND;
    return t[SUM_W-1:qpr_pkg::QUAT_FRAC];
  endfunction

  assign qw = $signed(quat[0]);
  assign qx = $signed(quat[1]);
  assign qy = $signed(quat[2]);
  assign qz = $signed(quat[3]);

  always_ff @(posedge clk) begin
    p_ww <= qw * qw;
    p_xx <= qx * qx;
    p_yy <= qy * qy;
    p_zz <= qz * qz;
    p_xy <= qx * qy;
    p_wz <= qw * qz;
    p_wy <= qw * qy;
    p_xz <= qx * qz;
    p_yz <= qy * qz;
    p_wx <= qw * qx;
  end

  always_ff @(posedge clk) begin
    mat[0][0] <= fold(sx(p_ww) + sx(p_xx) - sx(p_yy) - sx(p_zz));
    mat[0][1] <= fold((sx(p_xy) - sx(p_wz)) <<< 1);
    mat[0][2] <= fold((sx(p_wy) + sx(p_xz)) <<< 1);
    mat[1][0] <= fold((sx(p_xy) + sx(p_wz)) <<< 1);
    mat[1][1] <= fold(sx(p_ww) - sx(p_xx) + sx(p_yy) - sx(p_zz));
    mat[1][2] <= fold((sx(p_yz) - sx(p_wx)) <<< 1);
    mat[2][0] <= fold((sx(p_xz) - sx(p_wy)) <<< 1);
    mat[2][1] <= fold((sx(p_wx) + sx(p_yz)) <<< 1);
    mat[2][2] <= fold(sx(p_ww) - sx(p_xx) - sx(p_yy) + sx(p_zz));
  end

endmodule

/* src/quaternion_point_rotation_top.sv */
// One point per clock throughput; a point passes the d1, d2, pl3/ph3, prod4 and row5 registers
// and is then on the rotated ports, registered together with done high; busy stays low and
// the receiver cannot stall.
// Synchronous reset clears the pipeline valid bits and loads the identity quaternion
// and a zero centre; a reset is needed before the first request, as these start unknown.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module quaternion_point_rotation_top (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [qpr_pkg::COORD_WIDTH-1:0] point_x,
  input  logic signed [qpr_pkg::COORD_WIDTH-1:0] point_y,
  input  logic signed [qpr_pkg::COORD_WIDTH-1:0] point_z,
  output logic                                   done,
  output logic signed [qpr_pkg::COORD_WIDTH-1:0] rotated_x,
  output logic signed [qpr_pkg::COORD_WIDTH-1:0] rotated_y,
  output logic signed [qpr_pkg::COORD_WIDTH-1:0] rotated_z,
  input  logic                                   cfg_write,
  input  logic [2:0]                             cfg_addr,
  input  logic [qpr_pkg::QUAT_W-1:0]             cfg_data
);

  localparam int CW = qpr_pkg::COORD_WIDTH;

  qpr_pkg::quat_t quat;
  logic [2:0][CW-1:0] centre;
  qpr_pkg::mat_t mat;

  logic [2:0][CW-1:0] pt;
  logic accept;

  logic v1, v2, v3, v4, v5;
  logic [2:0][qpr_pkg::DIFF_W-1:0] d1, d2;
  logic [2:0][2:0][qpr_pkg::PL_W-1:0] pl3;
  logic [2:0][2:0][qpr_pkg::PH_W-1:0] ph3;
  logic [2:0][2:0][qpr_pkg::PROD_W-1:0] prod4;
  logic [2:0][qpr_pkg::ROW_W-1:0] row5;
  logic [2:0][CW-1:0] res_next;

  function automatic logic [qpr_pkg::ROW_W-1:0] row_sum(
    input logic [qpr_pkg::PROD_W-1:0] a,
    input logic [qpr_pkg::PROD_W-1:0] b,
    input logic [qpr_pkg::PROD_W-1:0] c
  );
    logic [qpr_pkg::ACC_W-1:0] acc;
    acc = {{2{a[qpr_pkg::PROD_W-1]}}, a} + {{2{b[qpr_pkg::PROD_W-1]}}, b}
        + {{2{c[qpr_pkg::PROD_W-1]}}, c} + qpr_pkg::ROUND_ACC;
    return acc[qpr_pkg::ACC_W-1:qpr_pkg::QUAT_FRAC];
  endfunction

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign pt[0]  = point_x;
  assign pt[1]  = point_y;
  assign pt[2]  = point_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      quat[0] <= qpr_pkg::QUAT_ONE;
      quat[1] <= '0;
      quat[2] <= '0;
      quat[3] <= '0;
      centre  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_addr)
        qpr_pkg::REG_QUAT_W:   quat[0]   <= cfg_data;
        qpr_pkg::REG_QUAT_X:   quat[1]   <= cfg_data;
        qpr_pkg::REG_QUAT_Y:   quat[2]   <= cfg_data;
        qpr_pkg::REG_QUAT_Z:   quat[3]   <= cfg_data;
        qpr_pkg::REG_CENTRE_X: centre[0] <= cfg_data[CW-1:0];
        qpr_pkg::REG_CENTRE_Y: centre[1] <= cfg_data[CW-1:0];
        qpr_pkg::REG_CENTRE_Z: centre[2] <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  qpr_matrix u_matrix (
    .clk  (clk),
    .quat (quat),
    .mat  (mat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      v5   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= accept;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      v5   <= v4;
      done <= v5;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      d1[c] <= $signed({pt[c][CW-1], pt[c]}) - $signed({centre[c][CW-1], centre[c]});
    end
    d2 <= d1;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        pl3[r][c] <= $signed({1'b0, mat[r][c][qpr_pkg::LO_W-1:0]}) * $signed(d2[c]);
        ph3[r][c] <= $signed(mat[r][c][qpr_pkg::ENTRY_W-1:qpr_pkg::LO_W]) * $signed(d2[c]);
        prod4[r][c] <= $signed({ph3[r][c], {qpr_pkg::LO_W{1'b0}}})
                     + $signed({{(qpr_pkg::PROD_W - qpr_pkg::PL_W){pl3[r][c][qpr_pkg::PL_W-1]}},
                                pl3[r][c]});
      end
    end
    for (int r = 0; r < 3; r++) begin
      row5[r] <= row_sum(prod4[r][0], prod4[r][1], prod4[r][2]);
    end
    if (v5) begin
      rotated_x <= res_next[0];
      rotated_y <= res_next[1];
      rotated_z <= res_next[2];
    end
  end

  // The centre is added back at full width and the sum is clamped to the coordinate range.
  always_comb begin
    logic [qpr_pkg::OSUM_W-1:0] s;
    logic [qpr_pkg::OSUM_W-CW:0] upper;
    res_next = '0;
    for (int r = 0; r < 3; r++) begin
      s = {row5[r][qpr_pkg::ROW_W-1], row5[r]}
        + {{(qpr_pkg::OSUM_W - CW){centre[r][CW-1]}}, centre[r]};
      upper = s[qpr_pkg::OSUM_W-1:CW-1];
      if ((&upper) || !(|upper)) begin
        res_next[r] = s[CW-1:0];
      end else if (s[qpr_pkg::OSUM_W-1]) begin
        res_next[r] = {1'b1, {(CW-1){1'b0}}};
      end else begin
        res_next[r] = {1'b0, {(CW-1){1'b1}}};
      end
    end
  end

  `ASSERT_AFTER(a_latency, clk, rst, accept, qpr_pkg::PIPE_LAT, done)
  `ASSERT_PAST(a_no_spurious, clk, rst, done, accept, qpr_pkg::PIPE_LAT)

endmodule
